### hdl/tld_pkg.sv
// Package for template list discovery: token kind codes and fixed widths.
// No dependencies; imported by template_list_discovery.
`default_nettype none

package tld_pkg;

  localparam int unsigned DefStackEntries = 16;
  localparam int unsigned DefPositionBits = 16;
  localparam int unsigned DepthBits       = 8;
  localparam int unsigned KindBits        = 4;

  typedef enum logic [KindBits-1:0] {
    KIND_IDENT    = 4'd0,
    KIND_LT       = 4'd1,
    KIND_GT       = 4'd2,
    KIND_GT_GT    = 4'd3,
    KIND_GT_EQ    = 4'd4,
    KIND_GT_GT_EQ = 4'd5,
    KIND_OPEN     = 4'd6,
    KIND_CLOSE    = 4'd7,
    KIND_RESET    = 4'd8,
    KIND_AND_OR   = 4'd9,
    KIND_OTHER    = 4'd10,
    KIND_END      = 4'd11
  } kind_e;

endpackage

`default_nettype wire

### hdl/template_list_discovery.sv
// Template list discovery top level: pending '<' stack in a synchronous memory.
// Depends on tld_pkg.
`default_nettype none

// Takes one lexer token per item (kind class and position) and reports each
// closed template list as a result item (opener position, closer position,
// offset of the closing '>' in its token, split kind, last flag). Identifiers,
// '<', open brackets, resets, end and other tokens are taken in S_IDLE and ready
// stays high. A closer on an empty stack stays in S_IDLE; otherwise S_CLOSE reads
// the top entry and returns to S_IDLE when it does not match; a matching two-'>'
// token with a second entry goes on through S_CLOSE2 and S_EMIT2, and emitting
// states wait while the result side stalls. Close brackets and '&&'/'||' stay in
// S_IDLE on an empty stack; otherwise S_POP pops the entries at or above the
// current depth, one read per entry. The pending stack lives in a synchronous
// memory with a registered read, and every look at the top entry goes through
// that read. One result register holds a finished result while the next token is taken in.
module template_list_discovery
  import tld_pkg::*;
#(
  parameter int unsigned STACK_ENTRIES = DefStackEntries,
  parameter int unsigned POSITION_BITS = DefPositionBits
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire  [KindBits-1:0]     token_kind_i,
  input  wire  [POSITION_BITS-1:0] token_position_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic [POSITION_BITS-1:0] opener_position_o,
  output logic [POSITION_BITS-1:0] closer_position_o,
  output logic                    closer_offset_o,
  output logic [1:0]              split_kind_o,
  output logic                    last_result_o
);

  localparam int unsigned IdxW   = $clog2(STACK_ENTRIES);
  localparam int unsigned CntW   = $clog2(STACK_ENTRIES + 1);
  localparam int unsigned EntryW = POSITION_BITS + DepthBits;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_POP    = 5'b00010,
    S_CLOSE  = 5'b00100,
    S_CLOSE2 = 5'b01000,
    S_EMIT2  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  kind_e                  kind_q, kind_d, kind_in;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] hold_pos_q, hold_pos_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [DepthBits-1:0]   depth_q, depth_d;
  logic                   after_q, after_d;

  logic [EntryW-1:0]      mem [STACK_ENTRIES];
  logic [EntryW-1:0]      rdata_q;
  logic                   rd_en, wr_en;
  logic [IdxW-1:0]        raddr, waddr;
  logic [EntryW-1:0]      wdata;
  logic [POSITION_BITS-1:0] rd_pos;
  logic [DepthBits-1:0]   rd_depth;

  logic                   out_valid_q, out_valid_d;
  logic [POSITION_BITS-1:0] opener_q, opener_d, closer_q, closer_d;
  logic                   off_q, off_d, last_q, last_d;
  logic [1:0]             split_q, split_d;
  logic                   emit, out_free, gts_two, has_eq, match;

  assign rd_pos   = rdata_q[EntryW-1:DepthBits];
  assign rd_depth = rdata_q[DepthBits-1:0];
  assign match    = (rd_depth == depth_q);
  assign gts_two  = (kind_q == KIND_GT_GT) || (kind_q == KIND_GT_GT_EQ);
  assign has_eq   = (kind_q == KIND_GT_EQ) || (kind_q == KIND_GT_GT_EQ);
  assign out_free = ~out_valid_q | out_ready_i;
  assign kind_in  = kind_e'(token_kind_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    pos_d      = pos_q;
    hold_pos_d = hold_pos_q;
    count_d    = count_q;
    depth_d    = depth_q;
    after_d    = after_q;
    rd_en      = 1'b0;
    raddr      = IdxW'(count_q - CntW'(1));
    wr_en      = 1'b0;
    waddr      = count_q[IdxW-1:0];
    wdata      = {pos_q, depth_q};
    emit       = 1'b0;
    opener_d   = opener_q;
    closer_d   = closer_q;
    off_d      = off_q;
    split_d    = split_q;
    last_d     = last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_in;
          pos_d   = token_position_i;
          after_d = (kind_in == KIND_IDENT);
          wdata   = {token_position_i, depth_q};
          case (kind_in)
            KIND_LT: begin
              if (after_q && (count_q < CntW'(STACK_ENTRIES))) begin
                wr_en   = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            KIND_GT, KIND_GT_GT, KIND_GT_EQ, KIND_GT_GT_EQ: begin
              if (count_q != '0) begin
                rd_en   = 1'b1;
                state_d = S_CLOSE;
              end
            end
            KIND_OPEN: begin
              if (depth_q != '1) depth_d = depth_q + DepthBits'(1);
            end
            KIND_CLOSE, KIND_AND_OR: begin
              if (count_q != '0) begin
                rd_en   = 1'b1;
                state_d = S_POP;
              end else if (kind_in == KIND_CLOSE && depth_q != '0) begin
                depth_d = depth_q - DepthBits'(1);
              end
            end
            KIND_RESET, KIND_END: begin
              count_d = '0;
              depth_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (rd_depth >= depth_q && count_q > CntW'(1)) begin
          count_d = count_q - CntW'(1);
          rd_en   = 1'b1;
          raddr   = IdxW'(count_q - CntW'(2));
        end else begin
          if (rd_depth >= depth_q) count_d = count_q - CntW'(1);
          if (kind_q == KIND_CLOSE && depth_q != '0) depth_d = depth_q - DepthBits'(1);
          state_d = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (!match) begin
          state_d = S_IDLE;
        end else if (gts_two && count_q > CntW'(1)) begin
          hold_pos_d = rd_pos;
          count_d    = count_q - CntW'(1);
          rd_en      = 1'b1;
          raddr      = IdxW'(count_q - CntW'(2));
          state_d    = S_CLOSE2;
        end else if (out_free) begin
          emit     = 1'b1;
          opener_d = rd_pos;
          off_d    = 1'b0;
          last_d   = 1'b1;
          count_d  = count_q - CntW'(1);
          if (!gts_two && has_eq) begin
            count_d = '0;
            depth_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      S_CLOSE2: begin
        if (out_free) begin
          emit     = 1'b1;
          opener_d = hold_pos_q;
          off_d    = 1'b0;
          last_d   = ~match;
          state_d  = match ? S_EMIT2 : S_IDLE;
        end
      end
      S_EMIT2: begin
        if (out_free) begin
          emit     = 1'b1;
          opener_d = rd_pos;
          off_d    = 1'b1;
          last_d   = 1'b1;
          count_d  = count_q - CntW'(1);
          if (has_eq) begin
            count_d = '0;
            depth_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      closer_d = pos_q;
      split_d  = 2'(kind_q - KIND_GT);
    end
    out_valid_d = emit | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      depth_q     <= '0;
      after_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      depth_q     <= depth_d;
      after_q     <= after_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    pos_q      <= pos_d;
    hold_pos_q <= hold_pos_d;
    opener_q   <= opener_d;
    closer_q   <= closer_d;
    off_q      <= off_d;
    split_q    <= split_d;
    last_q     <= last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign opener_position_o = opener_q;
  assign closer_position_o = closer_q;
  assign closer_offset_o   = off_q;
  assign split_kind_o      = split_q;
  assign last_result_o     = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_ENTRIES))
    else $error("stack count beyond capacity");

  a_emit2_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT2 |-> !last_q && !off_q)
    else $error("second closing without a pending first result");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> count_q <= $past(count_q))
    else $error("stack grew while popping");
`endif

endmodule

`default_nettype wire
